### hw/rtl/cscwn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cscwn_pkg
// Shared types and constants of the comment stripper / whitespace collapser.
// ----------------------------------------------------------------------------
package cscwn_pkg;

  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;

  // results per input beat and result queue geometry
  localparam int MaxRes = 3;
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    LEX_NORMAL,
    LEX_SLASH,
    LEX_LINE,
    LEX_BLOCK,
    LEX_BLOCK_STAR,
    LEX_LIT,
    LEX_LIT_ESC
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       end_of_text;
  } res_t;

  typedef struct packed {
    logic [1:0]            count;
    res_t [MaxRes-1:0]     item;
  } lex_out_t;

  typedef struct packed {
    lex_mode_t mode;
    logic      emitted_any;
  } lex_status_t;

  function automatic logic is_white(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/c_source_comment_whitespace_normalizer.sv
`default_nettype none
// the result queue registers a beat's results; its head drives the outputs
// throughput: one input beat per cycle while each beat yields at most one result and
//   out_ready is high; a beat with two or three results holds the input off until the
//   four-entry result queue drains back to one entry (one leaves per cycle with out_ready)
// reset: synchronous active-low rst_n returns the lexer to normal mode and empties the queue
// ----------------------------------------------------------------------------
// c_source_comment_whitespace_normalizer
// Strips C comments, collapses whitespace runs and trims the ends of a text,
// passing quoted literals through unchanged.
// ----------------------------------------------------------------------------
module c_source_comment_whitespace_normalizer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input beat channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last_byte,
  // result beat channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_end_of_text
);
  import cscwn_pkg::*;

  logic               accept;
  lex_out_t           lex_out;
  lex_status_t        lex_status;
  logic               room;
  logic [QCntW-1:0]   fill;

  // a beat is taken whenever the queue can absorb its worst case
  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  // lexer: state registers plus the single-pass result logic for the beat
  cscwn_lexer u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .lex_out      (lex_out),
    .status       (lex_status)
  );

  // result queue doubles as the output register, decoupling the two sides
  cscwn_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (accept),
    .lex_out         (lex_out),
    .room            (room),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_end_of_text (out_end_of_text),
    .fill            (fill)
  );

  // queue never overfills
  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill <= QCntW'(QDepth))
    else $error("result queue overfilled");

  // a beat without a byte is only ever the end marker
  a_bare_marker : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_end_of_text)
    else $error("empty result beat without end of text");

  // the last beat of a text puts the lexer back to its reset state
  a_last_resets : assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_byte |=> lex_status.mode == LEX_NORMAL && !lex_status.emitted_any)
    else $error("lexer not reset after end of text");

endmodule
`default_nettype wire

### hw/rtl/cscwn_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cscwn_lexer
// Lexer state and per-beat result generation (up to three results per beat).
// ----------------------------------------------------------------------------
module cscwn_lexer (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   accept,
  input  wire logic [7:0]             in_byte,
  input  wire logic                   in_last_byte,
  output cscwn_pkg::lex_out_t         lex_out,
  output cscwn_pkg::lex_status_t      status
);
  import cscwn_pkg::*;

  lex_mode_t mode_r, mode_nxt;
  logic      quote_dq_r, quote_dq_nxt;
  logic      space_pend_r, space_pend_nxt;
  logic      emitted_r, emitted_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= LEX_NORMAL;
      quote_dq_r   <= 1'b0;
      space_pend_r <= 1'b0;
      emitted_r    <= 1'b0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      quote_dq_r   <= quote_dq_nxt;
      space_pend_r <= space_pend_nxt;
      emitted_r    <= emitted_nxt;
    end
  end

  always_comb begin
    logic [7:0]        c;
    logic [7:0]        q;
    logic [1:0]        n_v;
    logic [7:0]        b_v [MaxRes];
    logic              sp_v;
    logic              em_v;
    logic              qd_v;
    logic              run_normal;
    lex_mode_t         md_v;

    c          = in_byte;
    q          = quote_dq_r ? ChDquote : ChSquote;
    n_v        = 2'd0;
    for (int k = 0; k < MaxRes; k++) b_v[k] = 8'h00;
    sp_v       = space_pend_r;
    em_v       = emitted_r;
    qd_v       = quote_dq_r;
    md_v       = mode_r;
    run_normal = 1'b0;

    case (mode_r)
      LEX_SLASH: begin
        if (c == ChSlash) begin
          md_v = LEX_LINE;
          sp_v = 1'b1;
        end else if (c == ChStar) begin
          md_v = LEX_BLOCK;
          sp_v = 1'b1;
        end else begin
          // held slash was a divide: owed space, then the slash
          if (sp_v && em_v) begin
            b_v[n_v] = ChSpace;
            n_v      = n_v + 2'd1;
          end
          sp_v       = 1'b0;
          b_v[n_v]   = ChSlash;
          n_v        = n_v + 2'd1;
          em_v       = 1'b1;
          md_v       = LEX_NORMAL;
          run_normal = 1'b1;
        end
      end
      LEX_LINE: begin
        if (c == ChLf) md_v = LEX_NORMAL;
      end
      LEX_BLOCK: begin
        if (c == ChStar) md_v = LEX_BLOCK_STAR;
      end
      LEX_BLOCK_STAR: begin
        if (c == ChSlash) md_v = LEX_NORMAL;
        else if (c != ChStar) md_v = LEX_BLOCK;
      end
      LEX_LIT: begin
        b_v[n_v] = c;
        n_v      = n_v + 2'd1;
        em_v     = 1'b1;
        if (c == ChBslash) md_v = LEX_LIT_ESC;
        else if (c == q) md_v = LEX_NORMAL;
      end
      LEX_LIT_ESC: begin
        b_v[n_v] = c;
        n_v      = n_v + 2'd1;
        em_v     = 1'b1;
        md_v     = LEX_LIT;
      end
      default: begin
        md_v       = LEX_NORMAL;
        run_normal = 1'b1;
      end
    endcase

    // ordinary byte handling, shared by normal mode and a resolved slash
    if (run_normal) begin
      if (c == ChSlash && !in_last_byte) begin
        md_v = LEX_SLASH;
      end else if (is_white(c)) begin
        sp_v = 1'b1;
      end else begin
        if (sp_v && em_v) begin
          b_v[n_v] = ChSpace;
          n_v      = n_v + 2'd1;
        end
        sp_v     = 1'b0;
        b_v[n_v] = c;
        n_v      = n_v + 2'd1;
        em_v     = 1'b1;
        if (c == ChDquote || c == ChSquote) begin
          qd_v = (c == ChDquote);
          md_v = LEX_LIT;
        end
      end
    end

    for (int k = 0; k < MaxRes; k++) begin
      lex_out.item[k].data        = b_v[k];
      lex_out.item[k].byte_valid  = 1'b1;
      lex_out.item[k].end_of_text = in_last_byte && (2'(k) == n_v - 2'd1);
    end
    lex_out.count = n_v;

    if (in_last_byte) begin
      if (n_v == 2'd0) begin
        // bare end marker
        lex_out.count                = 2'd1;
        lex_out.item[0].data         = 8'h00;
        lex_out.item[0].byte_valid   = 1'b0;
        lex_out.item[0].end_of_text  = 1'b1;
      end
      md_v = LEX_NORMAL;
      qd_v = 1'b0;
      sp_v = 1'b0;
      em_v = 1'b0;
    end

    mode_nxt       = md_v;
    quote_dq_nxt   = qd_v;
    space_pend_nxt = sp_v;
    emitted_nxt    = em_v;
  end

  assign status.mode        = mode_r;
  assign status.emitted_any = emitted_r;

endmodule
`default_nettype wire

### hw/rtl/cscwn_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cscwn_outq
// Result queue: takes up to three results per beat, delivers one per cycle while out_ready.
// ----------------------------------------------------------------------------
module cscwn_outq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire cscwn_pkg::lex_out_t           lex_out,
  output logic                               room,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_byte,
  output logic                               out_byte_valid,
  output logic                               out_end_of_text,
  output logic [cscwn_pkg::QCntW-1:0]        fill
);
  import cscwn_pkg::*;

  res_t              q_r [QDepth];
  logic [QPtrW-1:0]  rptr_r, rptr_nxt;
  logic [QPtrW-1:0]  wptr_r, wptr_nxt;
  logic [QCntW-1:0]  cnt_r, cnt_nxt;
  logic              pop;
  logic [QCntW-1:0]  push_n;

  assign pop    = out_valid && out_ready;
  assign push_n = push ? QCntW'(lex_out.count) : '0;

  always_comb begin
    rptr_nxt = pop ? rptr_r + QPtrW'(1) : rptr_r;
    wptr_nxt = wptr_r + QPtrW'(push_n);
    cnt_nxt  = cnt_r + push_n - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rptr_r <= '0;
      wptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      rptr_r <= rptr_nxt;
      wptr_r <= wptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (push && (2'(k) < lex_out.count)) begin
        q_r[wptr_r + QPtrW'(k)] <= lex_out.item[k];
      end
    end
  end

  // room for a worst-case beat
  assign room            = (cnt_r <= QCntW'(QDepth - MaxRes));
  assign out_valid       = (cnt_r != '0);
  assign out_byte        = q_r[rptr_r].data;
  assign out_byte_valid  = q_r[rptr_r].byte_valid;
  assign out_end_of_text = q_r[rptr_r].end_of_text;
  assign fill            = cnt_r;

endmodule
`default_nettype wire
